// ----- design/gws_pkg.sv -----
// ---------------------------------------------------------------------------
// gws_pkg: shared types and constants for the grid word search counter
// Letter codes, window and control types, match helpers.
// ---------------------------------------------------------------------------
package gws_pkg;

	localparam int GWS_MAX_WIDTH  = 256;
	localparam int GWS_MAX_HEIGHT = 256;
	localparam int RESET_SIZE     = 140;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int CHAR_W     = 8;
	localparam int WORD_W     = 18;
	localparam int CROSS_W    = 16;

	localparam logic [WORD_W-1:0]  WORD_MAX  = '1;
	localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

	localparam logic [CHAR_W-1:0] CHAR_X = 8'h58;
	localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_S = 8'h53;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic x;
		logic m;
		logic a;
		logic s;
	} letter_t;

	// window[row][col], row 3 and col 3 hold the newest characters
	typedef letter_t [3:0][3:0] window_t;

	typedef struct packed {
		logic c_ge3;
		logic c_ge2;
		logic r_ge3;
		logic r_ge2;
		logic last;
	} stage_flags_t;

	function automatic letter_t letter_of(input logic [CHAR_W-1:0] ch);
		letter_t l;
		l.x = (ch == CHAR_X);
		l.m = (ch == CHAR_M);
		l.a = (ch == CHAR_A);
		l.s = (ch == CHAR_S);
		return l;
	endfunction

	function automatic logic is_word(input letter_t a, input letter_t b,
		input letter_t c, input letter_t d);
		return (a.x & b.m & c.a & d.s) | (a.s & b.a & c.m & d.x);
	endfunction

	function automatic logic is_ms(input letter_t a, input letter_t b);
		return (a.m & b.s) | (a.s & b.m);
	endfunction

endpackage

// ----- design/gws_cell.sv -----
// ---------------------------------------------------------------------------
// gws_cell: one window cell
// Holds one character, hands it to its left neighbor on each shift and
// reports which search letter it holds.
// ---------------------------------------------------------------------------
module gws_cell import gws_pkg::*; (
	input  logic              clk,
	input  logic              shift,
	input  logic [CHAR_W-1:0] d,
	output logic [CHAR_W-1:0] q,
	output letter_t           letter
);

	logic [CHAR_W-1:0] char_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			char_q <= d;
		end
	end

	assign q      = char_q;
	assign letter = letter_of(char_q);

endmodule

// ----- design/gws_line_buf.sv -----
// ---------------------------------------------------------------------------
// gws_line_buf: three-row line buffer
// One word per column holds the three previous rows; registered read with
// write-to-read bypass for the same column.
// ---------------------------------------------------------------------------
module gws_line_buf import gws_pkg::*; #(
	parameter int MAX_WIDTH = GWS_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
	input  logic [3*CHAR_W-1:0]          wdata,
	input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
	output logic [3*CHAR_W-1:0]          rdata
);

	logic [3*CHAR_W-1:0] store_q [MAX_WIDTH];
	logic [3*CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/gws_counter.sv -----
// ---------------------------------------------------------------------------
// gws_counter: match logic and saturating totals
// Checks the four word directions and the cross on the window and keeps
// both running totals for the current grid.
// ---------------------------------------------------------------------------
module gws_counter import gws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  stage_flags_t       flags,
	input  window_t            window,
	output logic [WORD_W-1:0]  next_word,
	output logic [CROSS_W-1:0] next_cross
);

	logic [WORD_W-1:0]  word_q;
	logic [CROSS_W-1:0] cross_q;
	logic               hit_h, hit_v, hit_d, hit_ad, hit_x;
	logic [2:0]         hits;
	logic [WORD_W:0]    word_sum;

	always_comb begin
		hit_h  = flags.c_ge3 &&
			is_word(window[3][0], window[3][1], window[3][2], window[3][3]);
		hit_v  = flags.r_ge3 &&
			is_word(window[0][3], window[1][3], window[2][3], window[3][3]);
		hit_d  = flags.r_ge3 && flags.c_ge3 &&
			is_word(window[0][0], window[1][1], window[2][2], window[3][3]);
		hit_ad = flags.r_ge3 && flags.c_ge3 &&
			is_word(window[0][3], window[1][2], window[2][1], window[3][0]);
		hit_x  = flags.r_ge2 && flags.c_ge2 && window[2][2].a &&
			is_ms(window[1][1], window[3][3]) && is_ms(window[1][3], window[3][1]);

		hits = 3'(hit_h) + 3'(hit_v) + 3'(hit_d) + 3'(hit_ad);
		word_sum = {1'b0, word_q} + (WORD_W+1)'(hits);
		if (word_sum > {1'b0, WORD_MAX}) begin
			next_word = WORD_MAX;
		end else begin
			next_word = word_sum[WORD_W-1:0];
		end

		if (hit_x && (cross_q != CROSS_MAX)) begin
			next_cross = cross_q + CROSS_W'(1);
		end else begin
			next_cross = cross_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			cross_q <= '0;
		end else if (advance) begin
			if (flags.last) begin
				word_q  <= '0;
				cross_q <= '0;
			end else begin
				word_q  <= next_word;
				cross_q <= next_cross;
			end
		end
	end

endmodule

// ----- design/grid_word_search_counter_unit.sv -----
// ---------------------------------------------------------------------------
// grid_word_search_counter_unit: XMAS/SAMX and M/S cross counter
// Streams a character grid through a three-row line buffer and a 4x4 cell window.
//
// Usage:
//   Write grid_width (index 0) and grid_height (index 1) on the cfg port
//   while no grid is in flight; a value of 0 acts as 1, larger values
//   saturate at MAX_WIDTH / MAX_HEIGHT.
//   Send grid characters in row-major order on grid_char with
//   grid_valid / grid_stall, one request per character.
//   After the last character of the grid, one request on word_count and
//   cross_count appears with count_valid / count_stall; the totals clear.
// Timing:
//   One character per cycle sustained while grid_stall is low. The line
//   buffer is one memory column read and written per character, with the
//   read for the next column issued as the current one is written. Totals
//   go via the window stage to the result register and stay until taken.
// Reset and stall:
//   Reset clears position, totals and count_valid, and sets both sizes to 140;
//   line buffer contents stay undefined, no clearing pass is needed.
//   grid_stall rises only while a finished result is blocked by count_stall
//   and the next grid's last character is ready to leave the window stage.
// ---------------------------------------------------------------------------
module grid_word_search_counter_unit import gws_pkg::*; #(
	parameter int MAX_WIDTH  = GWS_MAX_WIDTH,
	parameter int MAX_HEIGHT = GWS_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  grid_valid,
	output logic                  grid_stall,
	input  logic [CHAR_W-1:0]     grid_char,
	output logic                  count_valid,
	input  logic                  count_stall,
	output logic [WORD_W-1:0]     word_count,
	output logic [CROSS_W-1:0]    cross_count
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int CWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
	localparam int CHW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
	localparam int RESET_W = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
	localparam int RESET_H = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

	logic [WW-1:0]  width_q;
	logic [HW-1:0]  height_q;
	logic [CWW-1:0] width_ext;
	logic [CHW-1:0] height_ext;
	logic [WW-1:0]  width_clamp;
	logic [HW-1:0]  height_clamp;

	logic [AW-1:0]  col_q;
	logic [AW-1:0]  col_d;
	logic [RW-1:0]  row_q;
	logic [WW-1:0]  col_inc;
	logic [HW-1:0]  row_inc;
	logic           row_wrap;
	logic           grid_end;
	logic           accept;

	logic [3*CHAR_W-1:0] buf_rdata;
	logic [3*CHAR_W-1:0] buf_wdata;
	logic [CHAR_W-1:0]   col_in [4];
	logic [CHAR_W-1:0]   cell_q [4][4];
	window_t             window;

	logic                s1_valid_q;
	stage_flags_t        flags_s1;
	stage_flags_t        flags_d;
	logic                out_blocked;
	logic                s1_adv;
	logic [WORD_W-1:0]   next_word;
	logic [CROSS_W-1:0]  next_cross;

	logic                count_valid_q;
	logic [WORD_W-1:0]   word_count_q;
	logic [CROSS_W-1:0]  cross_count_q;

	// size registers, clamped when written
	always_comb begin
		width_ext  = CWW'(cfg_data);
		height_ext = CHW'(cfg_data);
		if (width_ext == '0) begin
			width_clamp = WW'(1);
		end else if (width_ext > CWW'(MAX_WIDTH)) begin
			width_clamp = WW'(MAX_WIDTH);
		end else begin
			width_clamp = WW'(width_ext);
		end
		if (height_ext == '0) begin
			height_clamp = HW'(1);
		end else if (height_ext > CHW'(MAX_HEIGHT)) begin
			height_clamp = HW'(MAX_HEIGHT);
		end else begin
			height_clamp = HW'(height_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RESET_W);
			height_q <= HW'(RESET_H);
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_GRID_WIDTH:  width_q  <= width_clamp;
				REG_GRID_HEIGHT: height_q <= height_clamp;
				default: ;
			endcase
		end
	end

	// handshake
	assign out_blocked = count_valid_q && count_stall;
	assign grid_stall  = s1_valid_q && flags_s1.last && out_blocked;
	assign accept      = grid_valid && !grid_stall;
	assign s1_adv      = s1_valid_q && !(flags_s1.last && out_blocked);

	// grid position
	always_comb begin
		col_inc  = WW'(col_q) + WW'(1);
		row_inc  = HW'(row_q) + HW'(1);
		row_wrap = (col_inc >= width_q);
		grid_end = (row_inc >= height_q);
		col_d    = col_q;
		if (accept) begin
			col_d = row_wrap ? '0 : col_inc[AW-1:0];
		end
		flags_d.c_ge3 = (col_q >= AW'(3));
		flags_d.c_ge2 = (col_q >= AW'(2));
		flags_d.r_ge3 = (row_q >= RW'(3));
		flags_d.r_ge2 = (row_q >= RW'(2));
		flags_d.last  = row_wrap && grid_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			if (accept && row_wrap) begin
				row_q <= grid_end ? '0 : row_inc[RW-1:0];
			end
		end
	end

	// line buffer: word holds {row-1, row-2, row-3} of one column
	assign buf_wdata = {grid_char, buf_rdata[3*CHAR_W-1:2*CHAR_W],
		buf_rdata[2*CHAR_W-1:CHAR_W]};

	gws_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (buf_wdata),
		.raddr (col_d),
		.rdata (buf_rdata)
	);

	assign col_in[0] = buf_rdata[CHAR_W-1:0];
	assign col_in[1] = buf_rdata[2*CHAR_W-1:CHAR_W];
	assign col_in[2] = buf_rdata[3*CHAR_W-1:2*CHAR_W];
	assign col_in[3] = grid_char;

	// 4x4 window, each row a chain of cells shifting left
	for (genvar i = 0; i < 4; i++) begin : g_row
		for (genvar j = 0; j < 4; j++) begin : g_col
			logic [CHAR_W-1:0] cell_d;
			if (j == 3) begin : g_edge
				assign cell_d = col_in[i];
			end else begin : g_inner
				assign cell_d = cell_q[i][j+1];
			end
			gws_cell u_cell (
				.clk    (clk),
				.shift  (accept),
				.d      (cell_d),
				.q      (cell_q[i][j]),
				.letter (window[i][j])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags_d;
		end
	end

	gws_counter u_counter (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (s1_adv),
		.flags      (flags_s1),
		.window     (window),
		.next_word  (next_word),
		.next_cross (next_cross)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_valid_q <= 1'b0;
		end else if (s1_adv && flags_s1.last) begin
			count_valid_q <= 1'b1;
		end else if (!count_stall) begin
			count_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && flags_s1.last) begin
			word_count_q  <= next_word;
			cross_count_q <= next_cross;
		end
	end

	assign count_valid = count_valid_q;
	assign word_count  = word_count_q;
	assign cross_count = cross_count_q;

endmodule
